>>> src/assert_macros.svh
// Assertion macros used by the allocator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an implication holds at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Assert that a condition in the next cycle follows from a condition now.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

>>> src/gra_pkg.sv
// Package with the word types, operation codes and command types of the allocator.
package gra_pkg;
    localparam int unsigned OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_FIRST_FIT = 3'd0,
        OP_PLACE_AT  = 3'd1,
        OP_FREE      = 3'd2,
        OP_MOVE      = 3'd3,
        OP_CLEAR     = 3'd4
    } t_op;

    localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic [3:0] old_x;
        logic [3:0] old_y;
        logic [4:0] size_w;
        logic [4:0] size_h;
    } t_in_word;

    typedef struct packed {
        logic       success;
        logic [3:0] placed_x;
        logic [3:0] placed_y;
        logic       grid_full;
        logic       grid_empty;
    } t_out_word;

    // Datapath actions issued by the controller.
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_CHECK,
        DP_MARK_SET,
        DP_MARK_CLR,
        DP_CLEAR,
        DP_STATUS
    } t_dp_act;

    typedef struct packed {
        t_dp_act    act;
        logic [5:0] x;
        logic [5:0] y;
        logic       status_init;
    } t_dp_cmd;

    typedef struct packed {
        logic col_done;
        logic col_hit;
        logic status_done;
    } t_dp_sts;
endpackage

>>> src/gra_datapath.sv
// Datapath: occupancy bitmap, column walker for checks and marks, status sweep.
module gra_datapath
    import gra_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = 16,
    parameter int unsigned MAX_ROWS    = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_word  i_word,
    input  logic [4:0] i_gw,
    input  logic [4:0] i_gh,
    output t_dp_sts   o_sts,
    output logic      o_full,
    output logic      o_empty
);
    localparam int unsigned CW = $clog2(MAX_COLUMNS);

    logic [MAX_ROWS-1:0] r_occ [MAX_COLUMNS];
    logic [6:0]          r_col;
    logic [6:0]          n_col;
    logic                r_full;
    logic                r_empty;
    logic [6:0]          gw_eff;
    logic [6:0]          gh_eff;
    logic [6:0]          col_end;
    logic [MAX_ROWS-1:0] span;
    logic [MAX_ROWS-1:0] all_rows;
    logic [MAX_ROWS-1:0] col_word;
    logic                in_col;

    // Clip the configured grid to the built maximum.
    always_comb begin
        gw_eff = (7'(i_gw) > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : 7'(i_gw);
        gh_eff = (7'(i_gh) > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : 7'(i_gh);
        col_end = i_cmd.x + 7'(i_word.size_w);
    end

    // Row mask of the rectangle and of the whole grid in use.
    always_comb begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            span[r] = (7'(r) >= 7'(i_cmd.y)) && (7'(r) < 7'(i_cmd.y) + 7'(i_word.size_h))
                      && (7'(r) < gh_eff);
            all_rows[r] = 7'(r) < gh_eff;
        end
    end

    assign in_col   = (r_col < col_end) && (r_col < gw_eff);
    assign col_word = r_occ[r_col[CW-1:0]];

    // Walk columns one per cycle.
    always_comb begin
        n_col = r_col;
        o_sts.col_done = 1'b0;
        o_sts.col_hit = 1'b0;
        o_sts.status_done = 1'b0;
        unique case (i_cmd.act)
            DP_LOAD: n_col = 7'(i_cmd.x);
            DP_CHECK, DP_MARK_SET, DP_MARK_CLR: begin
                if (in_col) begin
                    n_col = r_col + 7'd1;
                    o_sts.col_hit = (i_cmd.act == DP_CHECK) && ((col_word & span) != '0);
                end else begin
                    o_sts.col_done = 1'b1;
                end
            end
            DP_CLEAR, DP_STATUS: begin
                if (r_col < gw_eff) n_col = r_col + 7'd1;
                else o_sts.status_done = 1'b1;
            end
            DP_NONE: n_col = 7'd0;
            default: n_col = r_col;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_full <= 1'b1;
            r_empty <= 1'b1;
            for (int c = 0; c < MAX_COLUMNS; c++) r_occ[c] <= '0;
        end else begin
            r_col <= n_col;
            if (i_cmd.status_init) begin
                r_full <= 1'b1;
                r_empty <= 1'b1;
            end
            case (i_cmd.act)
                DP_MARK_SET: if (in_col) r_occ[r_col[CW-1:0]] <= col_word | span;
                DP_MARK_CLR: if (in_col) r_occ[r_col[CW-1:0]] <= col_word & ~span;
                DP_CLEAR: if (r_col < gw_eff) r_occ[r_col[CW-1:0]] <= col_word & ~all_rows;
                DP_STATUS: if (r_col < gw_eff && !i_cmd.status_init) begin
                    if ((col_word & all_rows) != all_rows) r_full <= 1'b0;
                    if ((col_word & all_rows) != '0) r_empty <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_full  = r_full;
    assign o_empty = r_empty;
endmodule

>>> src/gra_controller.sv
// Controller: sequences checks, marks and the status sweep for each request.
module gra_controller
    import gra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_word,
    output t_in_word   o_word,
    output t_dp_cmd    o_cmd,
    input  t_dp_sts    i_sts,
    input  logic       i_full,
    input  logic       i_empty,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out,
    input  logic [6:0] i_gw_eff,
    input  logic [6:0] i_gh_eff
);
    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_LOAD, S_CHECK, S_MARK, S_FREE_OLD, S_RESTORE,
        S_CLEAR, S_STAT_LOAD, S_STATUS, S_OUT
    } t_state;

    t_state     r_state;
    t_in_word   r_word;
    logic [5:0] r_x, r_y;
    logic       r_ok;
    logic [3:0] r_rx, r_ry;
    logic       r_restore;
    logic       r_mark_set;
    logic       r_out_valid;
    t_out_word  r_out;
    logic       fits_bounds;
    logic       tgt_in;

    // Bounds part of the fit check at the current corner.
    assign fits_bounds = (7'(r_x) < i_gw_eff) && (7'(r_y) < i_gh_eff)
        && (7'(r_x) + 7'(r_word.size_w) <= i_gw_eff)
        && (7'(r_y) + 7'(r_word.size_h) <= i_gh_eff);
    assign tgt_in = (7'(r_word.pos_x) < i_gw_eff) && (7'(r_word.pos_y) < i_gh_eff);

    // Command to the datapath.
    always_comb begin
        o_cmd.x = r_x;
        o_cmd.y = r_y;
        o_cmd.status_init = (r_state == S_STAT_LOAD);
        unique case (r_state)
            S_LOAD, S_STAT_LOAD: o_cmd.act = DP_LOAD;
            S_CHECK:    o_cmd.act = DP_CHECK;
            S_MARK:     o_cmd.act = r_mark_set ? DP_MARK_SET : DP_MARK_CLR;
            S_FREE_OLD: o_cmd.act = DP_MARK_CLR;
            // Load the old corner first, then mark it only if it lies inside the grid.
            S_RESTORE:  o_cmd.act = r_restore ? DP_LOAD
                                              : (fits_bounds ? DP_MARK_SET : DP_NONE);
            S_CLEAR:    o_cmd.act = DP_CLEAR;
            S_STATUS:   o_cmd.act = DP_STATUS;
            default:    o_cmd.act = DP_NONE;
        endcase
        if (r_state == S_STAT_LOAD || r_state == S_CLEAR) o_cmd.x = '0;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_word      = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_word <= i_word;
                    r_ok <= 1'b0; r_rx <= '0; r_ry <= '0;
                    r_restore <= 1'b0;
                    r_state <= S_DECODE;
                end
                S_DECODE: begin
                    r_x <= '0; r_y <= '0;
                    r_mark_set <= 1'b1;
                    case (r_word.operation)
                        OP_FIRST_FIT: r_state <= S_LOAD;
                        OP_PLACE_AT: begin
                            r_x <= 6'(r_word.pos_x); r_y <= 6'(r_word.pos_y);
                            r_state <= S_LOAD;
                        end
                        OP_FREE: begin
                            r_x <= 6'(r_word.pos_x); r_y <= 6'(r_word.pos_y);
                            r_mark_set <= 1'b0; r_ok <= tgt_in;
                            r_state <= tgt_in ? S_LOAD : S_STAT_LOAD;
                        end
                        OP_MOVE: begin
                            r_rx <= r_word.old_x; r_ry <= r_word.old_y;
                            r_x <= 6'(r_word.old_x); r_y <= 6'(r_word.old_y);
                            r_state <= tgt_in ? S_LOAD : S_STAT_LOAD;
                            r_restore <= tgt_in;
                        end
                        OP_CLEAR: begin r_ok <= 1'b1; r_state <= S_CLEAR; end
                        default: r_state <= S_STAT_LOAD;
                    endcase
                end
                S_LOAD: begin
                    // After a fit was found, or for a free, the load leads to marking.
                    if (r_word.operation == OP_FREE || r_ok) r_state <= S_MARK;
                    else if (r_word.operation == OP_MOVE && r_restore) r_state <= S_FREE_OLD;
                    else r_state <= S_CHECK;
                end
                S_FREE_OLD: if (i_sts.col_done) begin
                    r_x <= 6'(r_word.pos_x); r_y <= 6'(r_word.pos_y);
                    r_restore <= 1'b0;
                    r_state <= S_LOAD;
                end
                S_CHECK: begin
                    if (!fits_bounds || i_sts.col_hit) begin
                        // No fit here: try the next corner, restore the old area of a move, or give up.
                        if (r_word.operation == OP_FIRST_FIT
                            && !(7'(r_x) + 7'd1 >= i_gw_eff && 7'(r_y) + 7'd1 >= i_gh_eff)) begin
                            if (7'(r_y) + 7'd1 < i_gh_eff) r_y <= r_y + 6'd1;
                            else begin r_y <= '0; r_x <= r_x + 6'd1; end
                            r_state <= S_LOAD;
                        end else if (r_word.operation == OP_MOVE) begin
                            r_x <= 6'(r_word.old_x); r_y <= 6'(r_word.old_y);
                            r_state <= S_RESTORE;
                            r_restore <= 1'b1;
                        end else begin
                            r_state <= S_STAT_LOAD;
                        end
                    end else if (i_sts.col_done) begin
                        r_ok <= 1'b1;
                        r_rx <= r_x[3:0]; r_ry <= r_y[3:0];
                        r_state <= S_LOAD;
                    end
                end
                S_RESTORE: begin
                    // Reload old corner, then mark it if it fits the grid.
                    if (r_restore) begin
                        r_restore <= 1'b0;
                    end else if (!fits_bounds) begin
                        r_state <= S_STAT_LOAD;
                    end else if (i_sts.col_done) begin
                        r_state <= S_STAT_LOAD;
                    end
                end
                S_MARK: if (i_sts.col_done) r_state <= S_STAT_LOAD;
                S_CLEAR: if (i_sts.status_done) r_state <= S_STAT_LOAD;
                S_STAT_LOAD: r_state <= S_STATUS;
                S_STATUS: if (i_sts.status_done) begin
                    r_out.success <= r_ok;
                    r_out.placed_x <= r_rx;
                    r_out.placed_y <= r_ry;
                    r_out.grid_full <= i_full;
                    r_out.grid_empty <= i_empty;
                    r_out_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLY(a_ready_idle, i_clk, i_rst_n, o_in_ready, !r_out_valid)
    `ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)
    `ASSERT_IMPLY(a_out_state, i_clk, i_rst_n, r_out_valid, r_state == S_OUT)
endmodule

>>> src/grid_rectangle_allocator_top.sv
// Sequence: decode; for each corner tried, a load and a column walk; for each area marked or
// freed and the old area of a move, a load and a column walk; a sweep of all columns for a
// clear; last a load and a status sweep over all columns. First fit may try every corner.
// Throughput: one word at a time; the next is accepted in the cycle after the result leaves.
// Reset: synchronous, active low; clears the bitmap, sets the grid to 16 x 16, no result pending.
// Top level: APB configuration, input and output word channels.
module grid_rectangle_allocator_top
    import gra_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = 16,
    parameter int unsigned MAX_ROWS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word
);
    logic [4:0] r_gw, r_gh;
    logic [6:0] gw_eff, gh_eff;
    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic       full, empty;
    t_in_word   word;

    assign pready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= 5'd16;
            r_gh <= 5'd16;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  r_gw <= pwdata[4:0];
                REG_GRID_HEIGHT: r_gh <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) prdata[4:0] = paddr[2] ? r_gh : r_gw;
    end

    assign gw_eff = (7'(r_gw) > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : 7'(r_gw);
    assign gh_eff = (7'(r_gh) > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : 7'(r_gh);

    gra_controller u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_word(i_in_word), .o_word(word),
        .o_cmd(cmd), .i_sts(sts), .i_full(full),
        .i_empty(empty), .o_out_valid, .i_out_ready, .o_out(o_out_word),
        .i_gw_eff(gw_eff), .i_gh_eff(gh_eff)
    );

    gra_datapath #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_word(word), .i_gw(r_gw), .i_gh(r_gh),
        .o_sts(sts), .o_full(full), .o_empty(empty)
    );
endmodule
